// ===== rtl/pdts_pkg.sv =====
package pdts_pkg;

  typedef enum logic [1:0] {
    ACT_CREATE = 2'd0,
    ACT_DELAY  = 2'd1,
    ACT_TICK   = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_RUNNING = 2'd2,
    ST_NO_TASK = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    INIT_READY   = 2'd0,
    INIT_BLOCKED = 2'd1,
    INIT_RUNNING = 2'd2,
    INIT_UNUSED  = 2'd3
  } init_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WAKE,
    S_DISPATCH,
    S_DONE
  } fsm_t;

  // Command broadcast from the controller to every cell of one queue.
  typedef struct packed {
    logic ins;   // insert the key below at its sorted place
    logic pop;   // drop the head, shift every entry toward the head
  } qcmd_t;

endpackage

// ===== rtl/pdts_if.sv =====
interface pdts_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] prio_in;
  logic [1:0] initial_state;
  logic [15:0] wait_ticks;
  modport source (output valid, action, prio_in, initial_state, wait_ticks, input ready);
  modport sink (input valid, action, prio_in, initial_state, wait_ticks, output ready);
endinterface

interface pdts_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [5:0]  slot_id;
  logic        dispatched;
  logic [31:0] tick_now;
  modport source (output valid, status, slot_id, dispatched, tick_now, input ready);
  modport sink (input valid, status, slot_id, dispatched, tick_now, output ready);
endinterface

// ===== rtl/pdts_cell.sv =====
// One entry of a sorted queue. Insert goes in front of the first entry whose
// key fails the "stay ahead" compare; equal keys keep FIFO order.
module pdts_cell #(
  parameter int KW = 8,
  parameter int IW = 4,
  parameter bit DESC = 1'b1
) (
  input  logic          clk,
  input  logic          rst,
  input  pdts_pkg::qcmd_t cmd,
  input  logic [KW-1:0] new_key,
  input  logic [IW-1:0] new_id,
  // neighbor toward the head
  input  logic          prev_valid,
  input  logic          prev_stays,
  input  logic [KW-1:0] prev_key,
  input  logic [IW-1:0] prev_id,
  // neighbor toward the tail
  input  logic          next_valid,
  input  logic [KW-1:0] next_key,
  input  logic [IW-1:0] next_id,
  output logic          valid,
  output logic          stays,
  output logic [KW-1:0] key,
  output logic [IW-1:0] id
);

  // Entry keeps its place on insert when it precedes the new key.
  assign stays = valid && (DESC ? (key >= new_key) : (key <= new_key));

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (cmd.pop) begin
      valid <= next_valid;
      key   <= next_key;
      id    <= next_id;
    end else if (cmd.ins) begin
      if (!stays && prev_stays) begin
        valid <= 1'b1;
        key   <= new_key;
        id    <= new_id;
      end else if (!stays) begin
        valid <= prev_valid;
        key   <= prev_key;
        id    <= prev_id;
      end
    end
  end

endmodule

// ===== rtl/pdts_queue.sv =====
// Sorted queue built from a row of cells; head is cell 0.
module pdts_queue #(
  parameter int N = 16,
  parameter int KW = 8,
  parameter int IW = 4,
  parameter bit DESC = 1'b1
) (
  input  logic            clk,
  input  logic            rst,
  input  pdts_pkg::qcmd_t cmd,
  input  logic [KW-1:0]   new_key,
  input  logic [IW-1:0]   new_id,
  output logic            head_valid,
  output logic [KW-1:0]   head_key,
  output logic [IW-1:0]   head_id
);

  logic [N:0]        v;
  logic [N:0]        st;
  logic [KW-1:0]     k [N+1];
  logic [IW-1:0]     d [N+1];

  // Tail sentinel: empty.
  assign v[N]  = 1'b0;
  assign st[N] = 1'b0;
  assign k[N]  = '0;
  assign d[N]  = '0;

  for (genvar i = 0; i < N; i++) begin : g_cell
    logic          pv, ps;
    logic [KW-1:0] pk;
    logic [IW-1:0] pd;
    if (i == 0) begin : g_head
      assign pv = 1'b0;
      assign ps = 1'b1;
      assign pk = '0;
      assign pd = '0;
    end else begin : g_body
      assign pv = v[i-1];
      assign ps = st[i-1];
      assign pk = k[i-1];
      assign pd = d[i-1];
    end
    pdts_cell #(.KW(KW), .IW(IW), .DESC(DESC)) u_cell (
      .clk, .rst, .cmd, .new_key, .new_id,
      .prev_valid(pv), .prev_stays(ps), .prev_key(pk), .prev_id(pd),
      .next_valid(v[i+1]), .next_key(k[i+1]), .next_id(d[i+1]),
      .valid(v[i]), .stays(st[i]), .key(k[i]), .id(d[i])
    );
  end

  assign head_valid = v[0];
  assign head_key   = k[0];
  assign head_id    = d[0];

endmodule

// ===== rtl/priority_delay_task_scheduler.sv =====
// Create, delay and an unused action are answered from the response register
// in the cycle after the request is taken; a tick passes through S_WAKE, which
// wakes due tasks one per cycle, and S_DISPATCH before its answer is registered.
// One request at a time; a new request is taken only in S_IDLE with the
// response register free.
// Reset: rst (synchronous, active high) empties both queues, the slot count,
// the tick counter and the running task; slot priorities are not cleared.
//
// Both queues are rows of cells that sort on insert: the ready row keyed by
// priority (descending), the blocked row keyed by wake tick (ascending).
// Each cell compares the broadcast key with its own entry and either holds,
// shifts one step toward the tail or captures the new entry. Pop shifts the
// whole row one step toward the head. A tick pops due blocked heads one per
// cycle and inserts each into the ready row in the same cycle.
module priority_delay_task_scheduler #(
  parameter int TASK_SLOTS = 16,
  parameter int PRIO_BITS  = 8
) (
  input  logic clk,
  input  logic rst,
  pdts_req_if.sink   req,
  pdts_rsp_if.source rsp
);

  localparam int IW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int CW = $clog2(TASK_SLOTS + 1);

  pdts_pkg::fsm_t state, state_next;

  logic [PRIO_BITS-1:0] slot_priority [TASK_SLOTS];
  logic [CW-1:0]        slots_used;
  logic [31:0]          tick_counter;
  logic                 running_valid;
  logic [IW-1:0]        running_slot;

  logic [1:0]  out_status;
  logic [5:0]  out_slot;
  logic        out_disp;
  logic        out_valid;

  pdts_pkg::qcmd_t      rcmd, bcmd;
  logic [PRIO_BITS-1:0] r_key;
  logic [IW-1:0]        r_id;
  logic [31:0]          b_key;
  logic [IW-1:0]        b_id;
  logic                 rh_v, bh_v;
  logic [PRIO_BITS-1:0] rh_k;
  logic [IW-1:0]        rh_d, bh_d;
  logic [31:0]          bh_k;

  pdts_queue #(.N(TASK_SLOTS), .KW(PRIO_BITS), .IW(IW), .DESC(1'b1)) u_ready (
    .clk, .rst, .cmd(rcmd), .new_key(r_key), .new_id(r_id),
    .head_valid(rh_v), .head_key(rh_k), .head_id(rh_d)
  );

  pdts_queue #(.N(TASK_SLOTS), .KW(32), .IW(IW), .DESC(1'b0)) u_blocked (
    .clk, .rst, .cmd(bcmd), .new_key(b_key), .new_id(b_id),
    .head_valid(bh_v), .head_key(bh_k), .head_id(bh_d)
  );

  logic take;
  assign req.ready = (state == pdts_pkg::S_IDLE) && !out_valid;
  assign take = req.valid && req.ready;

  logic full;
  logic [IW-1:0] new_slot;
  logic woke;
  assign full     = (slots_used == CW'(TASK_SLOTS));
  assign new_slot = slots_used[IW-1:0];
  assign woke     = bh_v && (bh_k <= tick_counter);

  // Queue commands and keys.
  always_comb begin
    rcmd  = '0;
    bcmd  = '0;
    r_key = PRIO_BITS'(req.prio_in);
    r_id  = new_slot;
    b_key = 32'd0;
    b_id  = new_slot;
    state_next = state;
    unique case (state)
      pdts_pkg::S_IDLE: begin
        if (take) begin
          unique case (pdts_pkg::action_t'(req.action))
            pdts_pkg::ACT_CREATE: begin
              if (!full && req.initial_state == pdts_pkg::INIT_READY) rcmd.ins = 1'b1;
              if (!full && req.initial_state == pdts_pkg::INIT_BLOCKED) bcmd.ins = 1'b1;
            end
            pdts_pkg::ACT_DELAY: begin
              b_key = tick_counter + 32'(req.wait_ticks);
              b_id  = running_slot;
              bcmd.ins = running_valid;
            end
            pdts_pkg::ACT_TICK: state_next = pdts_pkg::S_WAKE;
            default: ;
          endcase
        end
      end
      pdts_pkg::S_WAKE: begin
        if (woke) begin
          bcmd.pop = 1'b1;
          rcmd.ins = 1'b1;
          r_key = slot_priority[bh_d];
          r_id  = bh_d;
        end else begin
          state_next = pdts_pkg::S_DISPATCH;
        end
      end
      pdts_pkg::S_DISPATCH: begin
        rcmd.pop = rh_v;
        state_next = pdts_pkg::S_DONE;
      end
      pdts_pkg::S_DONE: state_next = pdts_pkg::S_IDLE;
      default: state_next = pdts_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= pdts_pkg::S_IDLE;
    else     state <= state_next;
  end

  // Slot table write on create.
  always_ff @(posedge clk) begin
    if (take && req.action == pdts_pkg::ACT_CREATE && !full)
      slot_priority[new_slot] <= PRIO_BITS'(req.prio_in);
  end

  // Control state and response register. A request is only taken with the
  // response register empty, and dispatch only runs after a taken tick, so
  // the three branches below never meet in one cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      slots_used    <= '0;
      tick_counter  <= '0;
      running_valid <= 1'b0;
      out_valid     <= 1'b0;
    end else if (take) begin
      unique case (pdts_pkg::action_t'(req.action))
        pdts_pkg::ACT_CREATE: begin
          out_valid <= 1'b1;
          out_disp  <= 1'b0;
          if (full) begin
            out_status <= pdts_pkg::ST_FULL;
            out_slot   <= '0;
          end else begin
            slots_used <= slots_used + 1'b1;
            out_slot   <= 6'(new_slot);
            if (req.initial_state == pdts_pkg::INIT_RUNNING ||
                req.initial_state == pdts_pkg::INIT_UNUSED)
              out_status <= pdts_pkg::ST_RUNNING;
            else
              out_status <= pdts_pkg::ST_OK;
          end
        end
        pdts_pkg::ACT_DELAY: begin
          out_valid <= 1'b1;
          out_disp  <= 1'b0;
          if (running_valid) begin
            out_status    <= pdts_pkg::ST_OK;
            out_slot      <= 6'(running_slot);
            running_valid <= 1'b0;
          end else begin
            out_status <= pdts_pkg::ST_NO_TASK;
            out_slot   <= '0;
          end
        end
        pdts_pkg::ACT_TICK: begin
          // Slot and dispatch flag are filled in at dispatch.
          tick_counter <= tick_counter + 32'd1;
          out_status   <= pdts_pkg::ST_OK;
        end
        default: begin
          out_valid  <= 1'b1;
          out_status <= pdts_pkg::ST_OK;
          out_slot   <= '0;
          out_disp   <= 1'b0;
        end
      endcase
    end else if (state == pdts_pkg::S_DISPATCH) begin
      out_valid     <= 1'b1;
      running_valid <= rh_v;
      running_slot  <= rh_d;
      out_disp      <= rh_v;
      out_slot      <= rh_v ? 6'(rh_d) : 6'd0;
    end else if (out_valid && rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.status     = out_status;
  assign rsp.slot_id    = out_slot;
  assign rsp.dispatched = out_disp;
  assign rsp.tick_now   = tick_counter;

endmodule
